// ===== hdl/qms_pkg.sv =====
`default_nettype none
package qms_pkg;

  localparam int MAX_NODES = 4096;
  localparam int MAX_EDGES = 8192;
  localparam int MAX_QUADS = 4096;

  localparam int VW     = 12;
  localparam int IW     = 14;
  localparam int EDGE_AW = 13;
  localparam int KEY_W  = 2 * VW;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_EDGES  = 2'd1;
  localparam logic [1:0] FUNC_EXPAND = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_NODE  = 2'd0;
  localparam logic [1:0] KIND_CHILD = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EFULL = 3'd1;
  localparam logic [2:0] ST_EMISS = 3'd2;
  localparam logic [2:0] ST_NFULL = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_LOAD,
    OP_ERR,
    OP_EDGE_INIT,
    OP_SRCH_START,
    OP_SRCH_STEP,
    OP_INSERT,
    OP_RD_Q,
    OP_MID,
    OP_EDGE_NEXT,
    OP_CEN_START,
    OP_CACC,
    OP_CHILD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       push;
    logic       last;
    logic [2:0] err;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       range_err;
    logic       nfull;
    logic       qfull;
    logic       efull;
    logic       hit;
    logic       miss;
    logic       edge_last;
    logic       cen_last;
    logic       child_last;
    logic       pend_vld;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/qms_ctrl.sv =====
`default_nettype none
module qms_ctrl import qms_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SINIT = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_MISS  = 4'd4;
  localparam logic [3:0] S_MRD   = 4'd5;
  localparam logic [3:0] S_MRD2  = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_CEN   = 4'd8;
  localparam logic [3:0] S_CH    = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, push: 1'b0, last: 1'b0, err: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_FIN;
        case (stat_i.func)
          FUNC_CLEAR: begin
            cmd_o.op = OP_CLEAR;
            state_d  = S_IDLE;
          end
          FUNC_LOAD: begin
            if (stat_i.nfull) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_NFULL;
            end else begin
              cmd_o.op = OP_LOAD;
            end
          end
          default: begin
            if (stat_i.range_err) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_RANGE;
            end else if (stat_i.func == FUNC_EXPAND && stat_i.qfull) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_NFULL;
            end else begin
              cmd_o.op = OP_EDGE_INIT;
              state_d  = S_SINIT;
            end
          end
        endcase
      end
      S_SINIT: begin
        cmd_o.op = OP_SRCH_START;
        state_d  = S_SRCH;
      end
      S_SRCH: begin
        cmd_o.op = OP_SRCH_STEP;
        if (stat_i.hit) begin
          state_d = S_NEXT;
        end else if (stat_i.miss) begin
          if (stat_i.func == FUNC_EXPAND) begin
            cmd_o.op  = OP_ERR;
            cmd_o.err = ST_EMISS;
            state_d   = S_FIN;
          end else begin
            state_d = S_MISS;
          end
        end
      end
      S_MISS: begin
        // hold until the previous word can move to the output register
        if (!stat_i.pend_vld || stat_i.out_free) begin
          cmd_o.push = stat_i.pend_vld;
          if (stat_i.efull) begin
            cmd_o.op  = OP_ERR;
            cmd_o.err = ST_EFULL;
            state_d   = S_FIN;
          end else begin
            cmd_o.op = OP_INSERT;
            state_d  = S_MRD;
          end
        end
      end
      S_MRD: begin
        cmd_o.op = OP_RD_Q;
        state_d  = S_MRD2;
      end
      S_MRD2: begin
        cmd_o.op = OP_MID;
        state_d  = S_NEXT;
      end
      S_NEXT: begin
        if (!stat_i.edge_last) begin
          cmd_o.op = OP_EDGE_NEXT;
          state_d  = S_SINIT;
        end else if (stat_i.func == FUNC_EXPAND) begin
          cmd_o.op = OP_CEN_START;
          state_d  = S_CEN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CEN: begin
        cmd_o.op = OP_CACC;
        if (stat_i.cen_last) begin
          state_d = S_CH;
        end
      end
      S_CH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.op   = OP_CHILD;
          if (stat_i.child_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!stat_i.pend_vld) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/qms_dp.sv =====
`default_nettype none
module qms_dp import qms_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  wire  [1:0]         func_i,
  input  wire signed [31:0]  node_x_i,
  input  wire signed [31:0]  node_y_i,
  input  wire  [VW-1:0]      vert_a_i,
  input  wire  [VW-1:0]      vert_b_i,
  input  wire  [VW-1:0]      vert_c_i,
  input  wire  [VW-1:0]      vert_d_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [1:0]         kind_o,
  output logic [IW-1:0]      item_index_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [IW-1:0]      child_a_o,
  output logic [IW-1:0]      child_b_o,
  output logic [IW-1:0]      child_c_o,
  output logic [IW-1:0]      child_d_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  logic [63:0]      node_mem [MAX_NODES];
  logic [KEY_W-1:0] edge_mem [MAX_EDGES];

  logic [12:0] nodes_q;
  logic [13:0] edges_q;
  logic [12:0] quads_q;

  logic [1:0]        func_q;
  logic [31:0]       in_x_q, in_y_q;
  logic [VW-1:0]     v_q [4];
  logic [1:0]        ei_q;
  logic [KEY_W-1:0]  key_q;
  logic [13:0]       j_q;
  logic              rd_vld_q;
  logic [EDGE_AW-1:0] rd_idx_q;
  logic [KEY_W-1:0]  edge_rdata_q;
  logic [63:0]       node_rdata_q;
  logic [VW-1:0]     node_raddr;
  logic signed [33:0] acc_x_q, acc_y_q;
  logic [2:0]        ci_q;
  logic [1:0]        k_q;
  logic [IW-1:0]     e_q [4];
  logic [IW-1:0]     c_q;

  // pending word: the last flag is known only when the next word or the end arrives
  logic              pend_vld_q;
  logic [1:0]        p_kind_q;
  logic [IW-1:0]     p_idx_q;
  logic [31:0]       p_x_q, p_y_q;
  logic [IW-1:0]     p_ch_q [4];
  logic [2:0]        p_st_q;

  logic              out_vld_q;

  logic [VW-1:0]     pa, pb, lo, hi;
  logic              hit, out_free, pend_set;
  logic signed [33:0] rx, ry, sum_x, sum_y;
  logic [IW:0]       cen_idx;
  logic [IW-1:0]     mid_idx;

  assign pa = v_q[ei_q];
  assign pb = v_q[ei_q + 2'd1];
  assign lo = (pa > pb) ? pb : pa;
  assign hi = (pa > pb) ? pa : pb;

  assign hit      = rd_vld_q && (edge_rdata_q == key_q);
  assign out_free = !out_vld_q || !out_stall_i;

  assign rx    = 34'(signed'(node_rdata_q[63:32]));
  assign ry    = 34'(signed'(node_rdata_q[31:0]));
  assign sum_x = acc_x_q + rx;
  assign sum_y = acc_y_q + ry;
  assign cen_idx = {2'b00, nodes_q} + {1'b0, edges_q} + {2'b00, quads_q};
  assign mid_idx = {1'b0, nodes_q} + edges_q;

  assign pend_set = (cmd_i.op == OP_LOAD) || (cmd_i.op == OP_ERR) || (cmd_i.op == OP_MID) ||
                    (cmd_i.op == OP_CHILD) || (cmd_i.op == OP_CACC && ci_q == 3'd4);

  always_comb begin
    stat_o.func       = func_q;
    stat_o.range_err  = ({1'b0, v_q[0]} >= nodes_q) || ({1'b0, v_q[1]} >= nodes_q) ||
                        ({1'b0, v_q[2]} >= nodes_q) || ({1'b0, v_q[3]} >= nodes_q);
    stat_o.nfull      = (32'(nodes_q) >= MAX_NODES);
    stat_o.qfull      = (32'(quads_q) >= MAX_QUADS);
    stat_o.efull      = (32'(edges_q) >= MAX_EDGES);
    stat_o.hit        = hit;
    stat_o.miss       = !hit && !rd_vld_q && (j_q >= edges_q);
    stat_o.edge_last  = (ei_q == 2'd3);
    stat_o.cen_last   = (ci_q == 3'd4);
    stat_o.child_last = (k_q == 2'd3);
    stat_o.pend_vld   = pend_vld_q;
    stat_o.out_free   = out_free;
  end

  always_comb begin
    case (cmd_i.op)
      OP_INSERT:    node_raddr = pa;
      OP_RD_Q:      node_raddr = pb;
      OP_CEN_START: node_raddr = v_q[0];
      OP_CACC:      node_raddr = v_q[ci_q[1:0]];
      default:      node_raddr = v_q[0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      node_mem[nodes_q[VW-1:0]] <= {in_x_q, in_y_q};
    end
    node_rdata_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_INSERT) begin
      edge_mem[edges_q[EDGE_AW-1:0]] <= key_q;
    end
    edge_rdata_q <= edge_mem[j_q[EDGE_AW-1:0]];
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        func_q <= func_i;
        in_x_q <= node_x_i;
        in_y_q <= node_y_i;
        v_q[0] <= vert_a_i;
        v_q[1] <= vert_b_i;
        v_q[2] <= vert_c_i;
        v_q[3] <= vert_d_i;
      end
      OP_EDGE_INIT: ei_q <= 2'd0;
      OP_EDGE_NEXT: ei_q <= ei_q + 2'd1;
      OP_SRCH_START: begin
        key_q <= {lo, hi};
        j_q   <= '0;
      end
      OP_SRCH_STEP: begin
        rd_idx_q <= j_q[EDGE_AW-1:0];
        if (j_q < edges_q) begin
          j_q <= j_q + 14'd1;
        end
        if (hit) begin
          e_q[ei_q] <= {1'b0, nodes_q} + {1'b0, rd_idx_q};
        end
      end
      OP_RD_Q: begin
        acc_x_q <= rx;
        acc_y_q <= ry;
      end
      OP_CEN_START: begin
        acc_x_q <= '0;
        acc_y_q <= '0;
        ci_q    <= 3'd1;
        k_q     <= 2'd0;
      end
      OP_CACC: begin
        if (ci_q != 3'd4) begin
          acc_x_q <= sum_x;
          acc_y_q <= sum_y;
          ci_q    <= ci_q + 3'd1;
        end else begin
          c_q <= cen_idx[IW-1:0];
        end
      end
      OP_CHILD: k_q <= k_q + 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (cmd_i.op == OP_SRCH_STEP) begin
      rd_vld_q <= (j_q < edges_q) && !hit;
    end else begin
      rd_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= '0;
      edges_q <= '0;
      quads_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_CLEAR: begin
          nodes_q <= '0;
          edges_q <= '0;
          quads_q <= '0;
        end
        OP_LOAD:  nodes_q <= nodes_q + 13'd1;
        OP_MID:   edges_q <= edges_q + 14'd1;
        OP_CHILD: if (k_q == 2'd3) quads_q <= quads_q + 13'd1;
        default: ;
      endcase
    end
  end

  // pending word and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (pend_set) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.push) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      kind_o       <= p_kind_q;
      item_index_o <= p_idx_q;
      out_x_o      <= p_x_q;
      out_y_o      <= p_y_q;
      child_a_o    <= p_ch_q[0];
      child_b_o    <= p_ch_q[1];
      child_c_o    <= p_ch_q[2];
      child_d_o    <= p_ch_q[3];
      status_o     <= p_st_q;
      last_o       <= cmd_i.last;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        p_kind_q <= KIND_NODE;
        p_idx_q  <= {1'b0, nodes_q};
        p_x_q    <= in_x_q;
        p_y_q    <= in_y_q;
        p_ch_q   <= '{default: '0};
        p_st_q   <= ST_OK;
      end
      OP_ERR: begin
        p_kind_q <= KIND_ERROR;
        p_idx_q  <= '0;
        p_x_q    <= '0;
        p_y_q    <= '0;
        p_ch_q   <= '{default: '0};
        p_st_q   <= cmd_i.err;
      end
      OP_MID: begin
        p_kind_q <= KIND_NODE;
        p_idx_q  <= mid_idx;
        p_x_q    <= sum_x[32:1];
        p_y_q    <= sum_y[32:1];
        p_ch_q   <= '{default: '0};
        p_st_q   <= ST_OK;
      end
      OP_CACC: begin
        if (ci_q == 3'd4) begin
          p_kind_q <= KIND_NODE;
          p_idx_q  <= cen_idx[IW-1:0];
          p_x_q    <= sum_x[33:2];
          p_y_q    <= sum_y[33:2];
          p_ch_q   <= '{default: '0};
          p_st_q   <= ST_OK;
        end
      end
      OP_CHILD: begin
        p_kind_q <= KIND_CHILD;
        p_idx_q  <= {quads_q[11:0], k_q};
        p_x_q    <= '0;
        p_y_q    <= '0;
        p_st_q   <= ST_OK;
        case (k_q)
          2'd0: p_ch_q <= '{{2'b00, v_q[0]}, e_q[0], c_q, e_q[3]};
          2'd1: p_ch_q <= '{e_q[0], {2'b00, v_q[1]}, e_q[1], c_q};
          2'd2: p_ch_q <= '{c_q, e_q[1], {2'b00, v_q[2]}, e_q[2]};
          default: p_ch_q <= '{e_q[3], c_q, e_q[2], {2'b00, v_q[3]}};
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (pend_vld_q && out_free))
    else $error("word pushed while output register busy or nothing pending");
  a_edges_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edges_q) <= MAX_EDGES)
    else $error("edge count beyond table size");
  a_nodes_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nodes_q) <= MAX_NODES)
    else $error("node count beyond store size");
  a_pend_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MID || cmd_i.op == OP_CHILD) |-> (!pend_vld_q || cmd_i.push))
    else $error("pending word overwritten");
`endif

endmodule
`default_nettype wire

// ===== hdl/quad_mesh_subdivide.sv =====
`default_nettype none
// Quad mesh midpoint subdivider. Items are handled one at a time; in_stall_o
// is high from acceptance until the item's results are queued. An item is
// accepted and then decoded; a node load stores its node at decode and then
// finishes. Each quad edge is looked up by a linear scan of the edge table
// through its single read port, one entry per cycle; a number-edges quad
// costs four such scans plus an insert and a midpoint computation per new
// edge, and an expand quad four scans plus a centroid sum and the four child
// quads, and the output side can stall each result word. Results leave
// through one output register backed by a one-word pending stage. No
// clearing pass after reset is needed.
module quad_mesh_subdivide import qms_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         func_i,
  input  wire signed [31:0]  node_x_i,
  input  wire signed [31:0]  node_y_i,
  input  wire  [VW-1:0]      vert_a_i,
  input  wire  [VW-1:0]      vert_b_i,
  input  wire  [VW-1:0]      vert_c_i,
  input  wire  [VW-1:0]      vert_d_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [1:0]         kind_o,
  output logic [IW-1:0]      item_index_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [IW-1:0]      child_a_o,
  output logic [IW-1:0]      child_b_o,
  output logic [IW-1:0]      child_c_o,
  output logic [IW-1:0]      child_d_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  cmd_t  cmd;
  stat_t stat;

  qms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  qms_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (func_i),
    .node_x_i     (node_x_i),
    .node_y_i     (node_y_i),
    .vert_a_i     (vert_a_i),
    .vert_b_i     (vert_b_i),
    .vert_c_i     (vert_c_i),
    .vert_d_i     (vert_d_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .item_index_o (item_index_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .child_a_o    (child_a_o),
    .child_b_o    (child_b_o),
    .child_c_o    (child_c_o),
    .child_d_o    (child_d_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

// ===== verif/tb_quad_mesh_subdivide.sv =====
`timescale 1ns / 1ps
module tb_quad_mesh_subdivide;
  import qms_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [3:0][VW-1:0] v;
    bit                 drain;
    bit                 quiet;
  } mesh_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IW-1:0]      idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [3:0][IW-1:0] ch;
    logic [2:0]         status;
    logic               last;
  } mesh_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_LOAD;
  logic signed [31:0] node_x = '0;
  logic signed [31:0] node_y = '0;
  logic [VW-1:0] vert_a = '0, vert_b = '0, vert_c = '0, vert_d = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [IW-1:0] item_index, child_a, child_b, child_c, child_d;
  logic signed [31:0] out_x, out_y;
  logic [2:0] status;
  logic last;

  quad_mesh_subdivide i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .node_x_i     (node_x),
    .node_y_i     (node_y),
    .vert_a_i     (vert_a),
    .vert_b_i     (vert_b),
    .vert_c_i     (vert_c),
    .vert_d_i     (vert_d),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .item_index_o (item_index),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .child_a_o    (child_a),
    .child_b_o    (child_b),
    .child_c_o    (child_c),
    .child_d_o    (child_d),
    .status_o     (status),
    .last_o       (last)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // mirror of the mesh tables
  logic signed [31:0] mirror_x [MAX_NODES];
  logic signed [31:0] mirror_y [MAX_NODES];
  logic [KEY_W-1:0]   mirror_key [MAX_EDGES];
  int unsigned n_nodes = 0, n_edges = 0, n_quads = 0;

  mesh_word_t pending_words[$];
  mesh_res_t  expected_results[$];
  int errors = 0;
  int n_queued = 0;
  bit quiet_mode = 1'b0;

  function automatic void push_result(logic [1:0] k, int unsigned idx, logic signed [31:0] x,
                                      logic signed [31:0] y, logic [3:0][IW-1:0] ch,
                                      logic [2:0] st, logic lst);
    mesh_res_t r;
    r.kind = k; r.idx = idx[IW-1:0]; r.x = x; r.y = y; r.ch = ch; r.status = st;
    r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic int find_edge(logic [VW-1:0] p, logic [VW-1:0] q);
    logic [KEY_W-1:0] key;
    key = (p > q) ? {q, p} : {p, q};
    for (int i = 0; i < n_edges && i < MAX_EDGES; i++)
      if (mirror_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void subdivide_word(mesh_word_t w);
    int start, idx, p, q;
    int unsigned e[4], c, base;
    longint sx, sy;
    logic [3:0][IW-1:0] zero_ch;
    bit bad;
    zero_ch = '0;
    bad = 1'b0;
    case (w.func)
      FUNC_CLEAR: begin
        n_nodes = 0; n_edges = 0; n_quads = 0;
      end
      FUNC_LOAD: begin
        if (n_nodes >= MAX_NODES) begin
          push_result(KIND_ERROR, 0, 0, 0, zero_ch, ST_NFULL, 1'b1);
        end else begin
          mirror_x[n_nodes] = w.x; mirror_y[n_nodes] = w.y;
          push_result(KIND_NODE, n_nodes, w.x, w.y, zero_ch, ST_OK, 1'b1);
          n_nodes++;
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) if (w.v[i] >= n_nodes) bad = 1'b1;
        if (bad) begin
          push_result(KIND_ERROR, 0, 0, 0, zero_ch, ST_RANGE, 1'b1);
        end else if (w.func == FUNC_EDGES) begin
          start = expected_results.size();
          for (int i = 0; i < 4; i++) begin
            p = w.v[i]; q = w.v[(i + 1) % 4];
            if (find_edge(p[VW-1:0], q[VW-1:0]) >= 0) continue;
            if (n_edges >= MAX_EDGES) begin
              push_result(KIND_ERROR, 0, 0, 0, zero_ch, ST_EFULL, 1'b0);
              break;
            end
            mirror_key[n_edges] = (p > q) ? {q[VW-1:0], p[VW-1:0]} : {p[VW-1:0], q[VW-1:0]};
            sx = (longint'(mirror_x[p]) + longint'(mirror_x[q])) >>> 1;
            sy = (longint'(mirror_y[p]) + longint'(mirror_y[q])) >>> 1;
            push_result(KIND_NODE, n_nodes + n_edges, sx[31:0], sy[31:0], zero_ch, ST_OK,
                        1'b0);
            n_edges++;
          end
          if (expected_results.size() > start)
            expected_results[expected_results.size() - 1].last = 1'b1;
        end else if (n_quads >= MAX_QUADS) begin
          push_result(KIND_ERROR, 0, 0, 0, zero_ch, ST_NFULL, 1'b1);
        end else begin
          sx = 0; sy = 0;
          for (int i = 0; i < 4; i++) begin
            idx = find_edge(w.v[i], w.v[(i + 1) % 4]);
            if (idx < 0) bad = 1'b1;
            e[i] = n_nodes + idx;
            sx += longint'(mirror_x[w.v[i]]);
            sy += longint'(mirror_y[w.v[i]]);
          end
          if (bad) begin
            push_result(KIND_ERROR, 0, 0, 0, zero_ch, ST_EMISS, 1'b1);
          end else begin
            c = n_nodes + n_edges + n_quads;
            base = n_quads * 4;
            sx = sx >>> 2; sy = sy >>> 2;
            push_result(KIND_NODE, c, sx[31:0], sy[31:0], zero_ch, ST_OK, 1'b0);
            push_result(KIND_CHILD, base, 0, 0,
                        {e[3][IW-1:0], c[IW-1:0], e[0][IW-1:0], IW'(w.v[0])}, ST_OK, 1'b0);
            push_result(KIND_CHILD, base + 1, 0, 0,
                        {c[IW-1:0], e[1][IW-1:0], IW'(w.v[1]), e[0][IW-1:0]}, ST_OK, 1'b0);
            push_result(KIND_CHILD, base + 2, 0, 0,
                        {e[2][IW-1:0], IW'(w.v[2]), e[1][IW-1:0], c[IW-1:0]}, ST_OK, 1'b0);
            push_result(KIND_CHILD, base + 3, 0, 0,
                        {IW'(w.v[3]), e[2][IW-1:0], c[IW-1:0], e[3][IW-1:0]}, ST_OK, 1'b1);
            n_quads++;
          end
        end
      end
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    if (quiet_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void queue_word(logic [1:0] f, logic signed [31:0] x, logic signed [31:0] y,
                                     int a, int b, int c, int d, bit drain = 0, bit quiet = 0);
    mesh_word_t w;
    w.func = f; w.x = x; w.y = y;
    w.v = {d[VW-1:0], c[VW-1:0], b[VW-1:0], a[VW-1:0]};
    w.drain = drain; w.quiet = quiet;
    pending_words.insert(pending_words.size(), w);
    n_queued++;
  endfunction

  // driver
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    mesh_word_t w;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        w.func = func; w.x = node_x; w.y = node_y;
        w.v = {vert_d, vert_c, vert_b, vert_a};
        subdivide_word(w);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && expected_results.size() != 0)) begin
          w = pending_words.pop_front();
          quiet_mode = w.quiet;
          func <= w.func; node_x <= w.x; node_y <= w.y;
          vert_a <= w.v[0]; vert_b <= w.v[1]; vert_c <= w.v[2]; vert_d <= w.v[3];
          in_valid <= 1'b1;
          gap_left = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    mesh_res_t got, want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind = kind; got.idx = item_index; got.x = out_x; got.y = out_y;
        got.ch = {child_d, child_c, child_b, child_a}; got.status = status; got.last = last;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word kind %0d idx %0d status %0d", $time, got.kind,
                   got.idx, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected kind %0d idx %0d x %h y %h ch %h st %0d last %0b",
                     $time, want.kind, want.idx, want.x, want.y, want.ch, want.status,
                     want.last);
            $display("%0t:          actual kind %0d idx %0d x %h y %h ch %h st %0d last %0b",
                     $time, got.kind, got.idx, got.x, got.y, got.ch, got.status, got.last);
          end
        end
        stall_left = draw_wait();
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // watchdog on cycles with no handshake
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL quad_mesh_subdivide");
      $finish;
    end
  end

  initial begin
    int n, nq;
    int qa[4][4];
    // directed: coordinate extremes, every function, range and missing-edge errors
    queue_word(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
    queue_word(FUNC_EXPAND, 0, 0, 0, 0, 0, 0);
    queue_word(FUNC_LOAD, 32'sh7fffffff, 32'sh80000000, 4095, 4095, 4095, 4095);
    queue_word(FUNC_LOAD, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0);
    queue_word(FUNC_LOAD, -1, 0, 0, 0, 0, 0);
    queue_word(FUNC_LOAD, 1, -1, 0, 0, 0, 0);
    queue_word(FUNC_LOAD, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
    queue_word(FUNC_EDGES, 0, 0, 0, 1, 2, 4095);
    queue_word(FUNC_EDGES, 0, 0, 0, 1, 2, 3);
    queue_word(FUNC_EDGES, 0, 0, 0, 1, 2, 3);
    queue_word(FUNC_EXPAND, 0, 0, 0, 2, 1, 3);
    queue_word(FUNC_EXPAND, 0, 0, 0, 1, 2, 3, 1);
    queue_word(FUNC_EDGES, 0, 0, 4, 4, 1, 1);
    queue_word(FUNC_EXPAND, 0, 0, 4, 4, 1, 1);
    queue_word(FUNC_EXPAND, 0, 0, 1, 2, 3, 0);
    queue_word(FUNC_EDGES, 0, 0, 4, 3, 2, 1, 1);
    queue_word(FUNC_EXPAND, 0, 0, 4, 3, 2, 1);
    // random scenes: load a small mesh, number edges, expand, plus noise
    while (n_queued < 235) begin
      queue_word(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, $urandom_range(0, 7) == 0);
      n = $urandom_range(4, 10);
      repeat (n) queue_word(FUNC_LOAD, $urandom, $urandom, 0, 0, 0, 0);
      nq = $urandom_range(1, 4);
      for (int k = 0; k < nq; k++) begin
        for (int j = 0; j < 4; j++) qa[k][j] = $urandom_range(0, n - 1);
        if ($urandom_range(0, 5) != 0)
          queue_word(FUNC_EDGES, 0, 0, qa[k][0], qa[k][1], qa[k][2], qa[k][3]);
      end
      if ($urandom_range(0, 2) == 0)
        queue_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
      for (int k = 0; k < nq; k++)
        queue_word(FUNC_EXPAND, 0, 0, qa[k][0], qa[k][1], qa[k][2], qa[k][3],
                   $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) == 0)
        queue_word(FUNC_EXPAND, 0, 0, qa[0][1], qa[0][0], qa[0][3], qa[0][2]);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("PASS quad_mesh_subdivide");
    else $display("FAIL quad_mesh_subdivide");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qms_pkg.sv
hdl/qms_ctrl.sv
hdl/qms_dp.sv
hdl/quad_mesh_subdivide.sv
verif/tb_quad_mesh_subdivide.sv
